### hdl/key_debounce_with_event_fifo_macros.svh
// assertion macros for the key debounce block
`ifndef KEY_DEBOUNCE_WITH_EVENT_FIFO_MACROS_SVH
`define KEY_DEBOUNCE_WITH_EVENT_FIFO_MACROS_SVH

// same-cycle implication, skipped during reset
`define KDB_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key debounce check failed");

// next-cycle implication, skipped during reset
`define KDB_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key debounce check failed");

// next-cycle implication, checked through reset as well
`define KDB_CHECK_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("key debounce check failed");

`endif

### hdl/kdb_pkg.sv
package kdb_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 16;

  localparam logic [7:0] CODE_K1_UP = 8'h10;
  localparam logic [7:0] CODE_K2_UP = 8'h20;
  localparam logic [7:0] CODE_K1_DN = 8'h11;
  localparam logic [7:0] CODE_K2_DN = 8'h21;
  localparam logic [7:0] CODE_NONE  = 8'h00;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [1:0] REG_DUAL_PULL   = 2'd0;
  localparam logic [1:0] REG_BUFFER_REL  = 2'd1;
  localparam logic [1:0] REG_PRESS_DELAY = 2'd2;
  localparam logic [1:0] REG_HOLD_FLOOR  = 2'd3;

  localparam logic [7:0] PRESS_DELAY_RESET = 8'd10;
  localparam logic [7:0] HOLD_FLOOR_RESET  = 8'd5;
  localparam logic [7:0] DELAY_RESET       = 8'hFF;

  typedef struct packed {
    logic       dual_pull_scan;
    logic       buffer_releases;
    logic [7:0] press_delay;
    logic [7:0] hold_floor;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic       is_read;
    logic [7:0] key;
  } op_t;

endpackage

### hdl/kdb_front.sv
module kdb_front
  import kdb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic key1_pullup_level,
  input  logic key2_pullup_level,
  input  logic key1_pulldown_level,
  input  logic key2_pulldown_level,
  output logic op_valid,
  input  logic op_ready,
  output op_t  op
);

  op_t        op_in;
  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // key code, later check wins
  always_comb begin
    op_in.is_read = req_type;
    op_in.key = CODE_NONE;
    if (!key1_pullup_level) op_in.key = CODE_K1_UP;
    if (!key2_pullup_level) op_in.key = CODE_K2_UP;
    if (cfg.dual_pull_scan) begin
      if (key1_pulldown_level) op_in.key = CODE_K1_DN;
      if (key2_pulldown_level) op_in.key = CODE_K2_DN;
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign op_valid = (count != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= op_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### hdl/kdb_back.sv
module kdb_back
  import kdb_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       op_valid,
  output logic       op_ready,
  input  op_t        op,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] key_code,
  output logic [7:0] read_code,
  output logic       fifo_empty,
  output logic       push_dropped
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       held_code, held_code_next;
  logic [7:0]       delay_count, delay_count_next;
  logic [PTR_W-1:0] read_ptr, write_ptr;
  logic [CNT_W-1:0] fill_count;
  logic             fire;
  logic             pop_en;
  logic             push_en;
  logic [1:0]       kind_next;
  logic [7:0]       code_next;
  logic             empty_next;
  logic             dropped_next;

  assign op_ready = !out_valid || out_ready;
  assign fire     = op_valid && op_ready;

  always_comb begin
    held_code_next   = held_code;
    delay_count_next = delay_count;
    kind_next        = EV_NONE;
    code_next        = CODE_NONE;
    empty_next       = 1'b0;
    dropped_next     = 1'b0;
    pop_en           = 1'b0;
    push_en          = 1'b0;
    if (op.is_read) begin
      if (fill_count != '0) pop_en = 1'b1;
      else empty_next = 1'b1;
    end else if (op.key != CODE_NONE) begin
      if (held_code != op.key) begin
        held_code_next   = op.key;
        delay_count_next = cfg.press_delay;
        kind_next        = EV_PRESS;
        code_next        = op.key;
      end else if (delay_count > cfg.hold_floor) begin
        delay_count_next = delay_count - 8'd1;
      end
    end else if (held_code != CODE_NONE) begin
      if (delay_count != 8'd0) begin
        delay_count_next = delay_count - 8'd1;
      end else begin
        if (cfg.buffer_releases) begin
          if (fill_count == CNT_FULL) dropped_next = 1'b1;
          else push_en = 1'b1;
        end
        kind_next      = EV_RELEASE;
        code_next      = held_code;
        held_code_next = CODE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push_en) mem[write_ptr] <= held_code;
  end

  // output payload, read data registered here
  always_ff @(posedge clk) begin
    if (fire) begin
      event_kind   <= kind_next;
      key_code     <= code_next;
      read_code    <= pop_en ? mem[read_ptr] : CODE_NONE;
      fifo_empty   <= empty_next;
      push_dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      held_code   <= CODE_NONE;
      delay_count <= DELAY_RESET;
      read_ptr    <= '0;
      write_ptr   <= '0;
      fill_count  <= '0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        held_code   <= held_code_next;
        delay_count <= delay_count_next;
        if (pop_en) begin
          read_ptr   <= (read_ptr == PTR_LAST) ? '0 : read_ptr + PTR_W'(1);
          fill_count <= fill_count - CNT_W'(1);
        end
        if (push_en) begin
          write_ptr  <= (write_ptr == PTR_LAST) ? '0 : write_ptr + PTR_W'(1);
          fill_count <= fill_count + CNT_W'(1);
        end
      end
    end
  end

endmodule

### hdl/key_debounce_with_event_fifo.sv
// Two-button key debouncer with release delay and a buffer of release codes.
// Input channel (in_valid/in_ready): req_type 0 is a scan tick carrying the
// four pin samples, req_type 1 reads the oldest buffered key code.
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order: press/release event and code for a scan, popped code or
// fifo_empty for a read, push_dropped when a release met a full buffer.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 dual
// pull scan, 1 buffer releases, 2 press delay, 3 hold floor); write only
// while no item is in flight.
// An accepted item passes through the two-entry queue and then the back end's
// output register before out_valid rises; throughput is one item per cycle
// while the receiver does not stall, set by the state update in the back end,
// which also owns the single-port key buffer with its registered read.
// A two-entry queue separates classification from the back end; when the
// receiver stalls the output register holds, the queue fills and in_ready
// drops after at most two more items.
// Synchronous reset empties the queue and output, clears the held key,
// sets the delay counter to 255 and restores register defaults; buffer
// contents are not cleared, the fill count makes them unreadable.
module key_debounce_with_event_fifo
  import kdb_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic       key1_pullup_level,
  input  logic       key2_pullup_level,
  input  logic       key1_pulldown_level,
  input  logic       key2_pulldown_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] key_code,
  output logic [7:0] read_code,
  output logic       fifo_empty,
  output logic       push_dropped,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic op_valid;
  logic op_ready;
  op_t  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dual_pull_scan  <= 1'b0;
      cfg.buffer_releases <= 1'b1;
      cfg.press_delay     <= PRESS_DELAY_RESET;
      cfg.hold_floor      <= HOLD_FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUAL_PULL:   cfg.dual_pull_scan  <= cfg_data[0];
        REG_BUFFER_REL:  cfg.buffer_releases <= cfg_data[0];
        REG_PRESS_DELAY: cfg.press_delay     <= cfg_data;
        REG_HOLD_FLOOR:  cfg.hold_floor      <= cfg_data;
        default: ;
      endcase
    end
  end

  kdb_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .req_type            (req_type),
    .key1_pullup_level   (key1_pullup_level),
    .key2_pullup_level   (key2_pullup_level),
    .key1_pulldown_level (key1_pulldown_level),
    .key2_pulldown_level (key2_pulldown_level),
    .op_valid            (op_valid),
    .op_ready            (op_ready),
    .op                  (op)
  );

  kdb_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .key_code     (key_code),
    .read_code    (read_code),
    .fifo_empty   (fifo_empty),
    .push_dropped (push_dropped)
  );

endmodule

### hdl/kdb_checker.sv
`include "key_debounce_with_event_fifo_macros.svh"

module kdb_checker
  import kdb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] key_code,
  input logic [7:0] read_code,
  input logic       fifo_empty,
  input logic       push_dropped
);

  `KDB_CHECK_NEXT(out_hold_a, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(key_code) && $stable(read_code) && $stable(fifo_empty) && $stable(push_dropped))
  `KDB_CHECK_NOW(empty_read_a, out_valid && fifo_empty, event_kind == EV_NONE && key_code == CODE_NONE && read_code == CODE_NONE && !push_dropped)
  `KDB_CHECK_NOW(no_event_a, out_valid && event_kind == EV_NONE, key_code == CODE_NONE && !push_dropped)
  `KDB_CHECK_NOW(drop_release_a, out_valid && push_dropped, event_kind == EV_RELEASE && key_code != CODE_NONE)
  `KDB_CHECK_NEXT_ALWAYS(reset_out_a, rst, !out_valid)

endmodule

bind key_debounce_with_event_fifo kdb_checker u_kdb_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_kind   (event_kind),
  .key_code     (key_code),
  .read_code    (read_code),
  .fifo_empty   (fifo_empty),
  .push_dropped (push_dropped)
);
